/* rtl/b43_pkg.sv */
// Shared types, constants and the character-to-digit lookup for the base43 decoder.
// No dependencies; used by the top level and the port checker.
`default_nettype none

package b43_pkg;

    // Storage for the big number: one byte per entry, least significant at entry 0.
    localparam int unsigned DEPTH     = 64;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned CARRY_W   = 6;
    localparam logic [7:0]  RADIX     = 8'd43;

    // Status codes carried in tuser.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CHAR = 2'd1;
    localparam logic [1:0] STATUS_LONG = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } digit_t;

    // Alphabet: 0-9, A-Z, then $ * + - . / :
    function automatic digit_t digit_of(input logic [7:0] code);
        digit_t d;
        d.ok    = 1'b1;
        d.value = 6'd0;
        if (code >= 8'h30 && code <= 8'h39) begin
            d.value = 6'(code - 8'h30);
        end else if (code >= 8'h41 && code <= 8'h5A) begin
            d.value = 6'(code - 8'h37);
        end else begin
            case (code)
                8'h24:   d.value = 6'd36;
                8'h2A:   d.value = 6'd37;
                8'h2B:   d.value = 6'd38;
                8'h2D:   d.value = 6'd39;
                8'h2E:   d.value = 6'd40;
                8'h2F:   d.value = 6'd41;
                8'h3A:   d.value = 6'd42;
                default: d.ok    = 1'b0;
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/b43_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module b43_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/base43_text_decoder_top.sv */
// Streaming base43 string decoder: top level with control sequencer and output register.
// Depends on b43_pkg and b43_ram.
`default_nettype none

// Channel   Direction  tdata                 tuser         tlast
// s_        in         [7:0] char_code       -             is_last
// m_        out        [7:0] data_byte       [1:0] status  end_of_run
//
// A character is accepted, then the multiply pass does one RAM read-modify-write per stored
// byte, leaves the pass and appends the carry; after an error a character is only accepted.
// After the last character FINISH settles the result; PAD then sends each padding zero and
// turns to the stored bytes, each read in RD and sent from RDW. Output stalls hold PAD and RDW.
// Reset is synchronous and active low. The RAM is not cleared: only bytes written in the
// current string are used. A finished result may wait in the output register meanwhile.

module base43_text_decoder_top #(
    parameter int unsigned MAX_CHARS = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tlast,   // is_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] data_byte
    output logic      [1:0] m_tuser,   // [1:0] status
    output logic            m_tlast    // end_of_run
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_PAD    = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_RDW    = 3'd6;

    localparam int unsigned AW = b43_pkg::ADDR_W;
    localparam int unsigned CW = b43_pkg::CNT_W;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] pad_reg, pad_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          lead_reg, lead_next;
    logic [1:0]    err_reg, err_next;
    logic          last_reg, last_next;
    logic [b43_pkg::CARRY_W-1:0] carry_reg, carry_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic [1:0] m_status_reg, m_status_next;
    logic       m_last_reg, m_last_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic [13:0]      prod;
    logic [7:0]       total;
    logic [1:0]       err_eff;
    logic             out_free;
    b43_pkg::digit_t  dig;

    b43_ram #(
        .WIDTH (8),
        .DEPTH (b43_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // One byte of the running product: byte * 43 + carry.
    assign prod     = 14'(rd_data) * 14'(b43_pkg::RADIX) + 14'(carry_reg);
    assign dig      = b43_pkg::digit_of(s_tdata);
    assign total    = 8'(pad_reg) + 8'(len_reg);
    assign out_free = !m_valid_reg || m_tready;

    // The RAM reads one entry ahead during the multiply pass, and the entry
    // below the down-counter while bytes are sent out.
    always_comb begin
        case (state_reg)
            ST_MUL:        rd_addr = AW'(idx_reg + 7'd1);
            ST_RD, ST_RDW: rd_addr = AW'(idx_reg - 7'd1);
            default:       rd_addr = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        pad_next      = pad_reg;
        cnt_next      = cnt_reg;
        lead_next     = lead_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        carry_next    = carry_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = AW'(idx_reg);
        wr_data       = prod[7:0];
        s_tready      = (state_reg == ST_IDLE);

        err_eff = err_reg;
        if (err_reg == b43_pkg::STATUS_OK &&
            (total > 8'(b43_pkg::DEPTH) || total == 8'd0)) begin
            err_eff = b43_pkg::STATUS_LONG;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? ST_FINISH : ST_IDLE;
                    if (cnt_reg >= CW'(MAX_CHARS)) begin
                        if (err_reg == b43_pkg::STATUS_OK) begin
                            err_next = b43_pkg::STATUS_LONG;
                        end
                    end else begin
                        cnt_next = cnt_reg + 7'd1;
                        if (err_reg != b43_pkg::STATUS_OK) begin
                            // Error already set: consume without arithmetic.
                        end else if (!dig.ok) begin
                            err_next = b43_pkg::STATUS_CHAR;
                        end else begin
                            if (lead_reg && dig.value == 6'd0) begin
                                pad_next = pad_reg + 7'd1;
                            end else begin
                                lead_next = 1'b0;
                            end
                            carry_next = dig.value;
                            idx_next   = '0;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                if (idx_reg == len_reg) begin
                    state_next = ST_APPEND;
                end else begin
                    wr_en      = 1'b1;
                    carry_next = prod[13:8];
                    idx_next   = idx_reg + 7'd1;
                end
            end
            ST_APPEND: begin
                if (carry_reg != '0) begin
                    if (len_reg >= CW'(b43_pkg::DEPTH)) begin
                        err_next = b43_pkg::STATUS_LONG;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(len_reg);
                        wr_data  = 8'(carry_reg);
                        len_next = len_reg + 7'd1;
                    end
                end
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (err_eff != b43_pkg::STATUS_OK) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_data_next   = 8'd0;
                        m_status_next = err_eff;
                        m_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    idx_next   = pad_reg;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (idx_reg == '0) begin
                    idx_next   = len_reg;
                    state_next = ST_RD;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = 8'd0;
                    m_status_next = b43_pkg::STATUS_OK;
                    m_last_next   = (idx_reg == 7'd1) && (len_reg == '0);
                    idx_next      = idx_reg - 7'd1;
                    if (idx_reg == 7'd1 && len_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_RDW;
            end
            ST_RDW: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_data;
                    m_status_next = b43_pkg::STATUS_OK;
                    m_last_next   = (idx_reg == 7'd1);
                    idx_next      = idx_reg - 7'd1;
                    state_next    = (idx_reg == 7'd1) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Leaving toward idle after the final result starts a fresh string.
        if (state_reg != ST_IDLE && state_reg != ST_MUL && state_reg != ST_APPEND &&
            state_next == ST_IDLE) begin
            len_next  = '0;
            pad_next  = '0;
            cnt_next  = '0;
            lead_next = 1'b1;
            err_next  = b43_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            pad_reg     <= '0;
            cnt_reg     <= '0;
            lead_reg    <= 1'b1;
            err_reg     <= b43_pkg::STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            pad_reg     <= pad_next;
            cnt_reg     <= cnt_next;
            lead_reg    <= lead_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        carry_reg    <= carry_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/b43_check.sv */
// Port-level checker for the base43 decoder, bound to the top level.
// Depends on b43_pkg and base43_text_decoder_top.
`default_nettype none

module b43_check (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // A status result always closes its string.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != b43_pkg::STATUS_OK |-> m_tlast)
        else $error("status result without end of run");

    // A status result carries no byte.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != b43_pkg::STATUS_OK |-> m_tdata == 8'd0)
        else $error("status result with nonzero byte");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == b43_pkg::STATUS_OK || m_tuser == b43_pkg::STATUS_CHAR ||
                     m_tuser == b43_pkg::STATUS_LONG)
        else $error("undefined status code");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind base43_text_decoder_top b43_check u_b43_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
